FILE: hw/rtl/pedsel_pkg.sv
// Shared types and constants of the PE image digest byte selector.
package pedsel_pkg;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NOT_PE      = 4'd1,
        ST_DOS_SHORT   = 4'd2,
        ST_OFFSET_HIGH = 4'd3,
        ST_NO_MARKER   = 4'd4,
        ST_BAD_MAGIC   = 4'd5,
        ST_FEW_DIRS    = 4'd6,
        ST_HDR_SHORT   = 4'd7,
        ST_SIG_NOT_END = 4'd8,
        ST_OVERLAP     = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       to_digest;
        t_status    status;
        logic       is_end;
        logic [2:0] pad_cnt;
    } t_result;

    localparam logic [7:0]  CHAR_M        = 8'h4D;
    localparam logic [7:0]  CHAR_Z        = 8'h5A;
    localparam logic [7:0]  CHAR_P        = 8'h50;
    localparam logic [7:0]  CHAR_E        = 8'h45;
    localparam logic [15:0] MAGIC_NARROW  = 16'h010B;
    localparam logic [15:0] MAGIC_WIDE    = 16'h020B;
    localparam logic [31:0] DOS_LEN       = 32'd64;
    localparam logic [31:0] TINY_LIMIT    = 32'd3;
    localparam logic [32:0] HDR_SPAN      = 33'd160;
    localparam logic [32:0] WIDE_EXTRA    = 33'd16;
    localparam logic [7:0]  WIDE_EXTRA_B  = 8'd16;
    localparam logic [7:0]  MARKER_LEN    = 8'd4;
    localparam logic [7:0]  MAGIC_OFS     = 8'd24;
    localparam logic [7:0]  CHECKSUM_OFS  = 8'd88;
    localparam logic [7:0]  CHECKSUM_END  = 8'd92;
    localparam logic [7:0]  DIR_COUNT_OFS = 8'd116;
    localparam logic [7:0]  CERT_OFS      = 8'd152;
    localparam logic [7:0]  CERT_LEN_OFS  = 8'd156;
    localparam logic [7:0]  CERT_END      = 8'd160;
    localparam logic [31:0] MIN_DIRS      = 32'd5;

endpackage

FILE: hw/rtl/pedsel_parse.sv
// Per-image header parser: checks, field capture and digest flag for one word.
module pedsel_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  logic [31:0]          i_image_size,
    output pedsel_pkg::t_result  o_res
);

    logic [31:0]          r_pos;
    logic [31:0]          r_hdr;
    logic                 r_wide;
    logic [7:0]           r_magic_lo;
    logic [31:0]          r_dir;
    logic [31:0]          r_sig_off;
    logic [31:0]          r_sig_len;
    logic [32:0]          r_lim;
    pedsel_pkg::t_status  r_err;

    logic [31:0]          n_hdr;
    logic                 n_wide;
    logic [7:0]           n_magic_lo;
    logic [31:0]          n_dir;
    logic [31:0]          n_sig_off;
    logic [31:0]          n_sig_len;
    logic [32:0]          n_lim;
    pedsel_pkg::t_status  n_err;

    logic [32:0] diff;
    logic [31:0] d;
    logic [7:0]  d8;
    logic        at_or_past;
    logic        past_dos;
    logic        rel;
    logic        in_hdr;
    logic [7:0]  w8;
    logic [7:0]  nw8;
    logic [31:0] sh_q;
    logic [31:0] sh_d;
    logic [31:0] hdr_new;
    logic [32:0] lim63;
    logic [32:0] pos_inc;
    logic [32:0] size33;
    logic        is_end;
    logic [15:0] magic;
    logic [31:0] kept;
    logic [32:0] sig_sum;
    logic        digest;
    logic [2:0]  kept_lo;

    assign size33     = {1'b0, i_image_size};
    assign diff       = {1'b0, r_pos} - {1'b0, r_hdr};
    assign d          = diff[31:0];
    assign d8         = d[7:0];
    assign at_or_past = ~diff[32];
    assign past_dos   = (r_pos[31:6] != 26'd0);
    assign rel        = past_dos && at_or_past && (d[31:8] == 24'd0);
    assign in_hdr     = (r_pos[31:6] == 26'd0) && (r_pos[5:2] == 4'hF);
    assign w8         = r_wide ? pedsel_pkg::WIDE_EXTRA_B : 8'd0;
    assign nw8        = n_wide ? pedsel_pkg::WIDE_EXTRA_B : 8'd0;
    assign sh_q       = {24'd0, i_byte} << {r_pos[1:0], 3'b000};
    assign sh_d       = {24'd0, i_byte} << {d8[1:0], 3'b000};
    assign hdr_new    = r_hdr | sh_q;
    assign lim63      = {1'b0, hdr_new} + pedsel_pkg::HDR_SPAN;
    assign pos_inc    = {1'b0, r_pos} + 33'd1;
    assign is_end     = (pos_inc >= size33);
    assign magic      = {i_byte, r_magic_lo};
    assign kept       = (r_sig_off != 32'd0) ? r_sig_off : i_image_size;
    assign sig_sum    = {1'b0, r_sig_off} + {1'b0, r_sig_len | sh_d};

    always_comb begin
        n_hdr      = r_hdr;
        n_wide     = r_wide;
        n_magic_lo = r_magic_lo;
        n_dir      = r_dir;
        n_sig_off  = r_sig_off;
        n_sig_len  = r_sig_len;
        n_lim      = r_lim;
        n_err      = r_err;
        if (r_err == pedsel_pkg::ST_OK) begin
            priority if (r_pos == 32'd0) begin
                if (i_image_size < pedsel_pkg::TINY_LIMIT || i_byte != pedsel_pkg::CHAR_M) begin
                    n_err = pedsel_pkg::ST_NOT_PE;
                end
            end else if (r_pos == 32'd1) begin
                if (i_byte != pedsel_pkg::CHAR_Z) begin
                    n_err = pedsel_pkg::ST_NOT_PE;
                end else if (i_image_size < pedsel_pkg::DOS_LEN) begin
                    n_err = pedsel_pkg::ST_DOS_SHORT;
                end
            end else if (in_hdr) begin
                n_hdr = hdr_new;
                if (r_pos[1:0] == 2'd3) begin
                    n_lim = lim63;
                    if (lim63 > size33) begin
                        n_err = pedsel_pkg::ST_OFFSET_HIGH;
                    end else if (hdr_new < pedsel_pkg::DOS_LEN) begin
                        n_err = pedsel_pkg::ST_OVERLAP;
                    end
                end
            end else if (rel && d8 < pedsel_pkg::MARKER_LEN) begin
                unique case (d8[1:0])
                    2'd0:    if (i_byte != pedsel_pkg::CHAR_P) n_err = pedsel_pkg::ST_NO_MARKER;
                    2'd1:    if (i_byte != pedsel_pkg::CHAR_E) n_err = pedsel_pkg::ST_NO_MARKER;
                    default: if (i_byte != 8'd0) n_err = pedsel_pkg::ST_NO_MARKER;
                endcase
            end else if (rel && d8 == pedsel_pkg::MAGIC_OFS) begin
                n_magic_lo = i_byte;
            end else if (rel && d8 == pedsel_pkg::MAGIC_OFS + 8'd1) begin
                if (magic == pedsel_pkg::MAGIC_WIDE) begin
                    n_wide = 1'b1;
                    n_lim  = r_lim + pedsel_pkg::WIDE_EXTRA;
                end else if (magic == pedsel_pkg::MAGIC_NARROW) begin
                    n_wide = 1'b0;
                end else begin
                    n_err = pedsel_pkg::ST_BAD_MAGIC;
                end
            end else if (rel && d8 >= pedsel_pkg::DIR_COUNT_OFS + w8
                         && d8 < pedsel_pkg::DIR_COUNT_OFS + 8'd4 + w8) begin
                n_dir = r_dir | sh_d;
                if (d8 == pedsel_pkg::DIR_COUNT_OFS + 8'd3 + w8) begin
                    if (n_dir < pedsel_pkg::MIN_DIRS) begin
                        n_err = pedsel_pkg::ST_FEW_DIRS;
                    end else if (size33 < r_lim) begin
                        n_err = pedsel_pkg::ST_HDR_SHORT;
                    end
                end
            end else if (rel && d8 >= pedsel_pkg::CERT_OFS + w8
                         && d8 < pedsel_pkg::CERT_LEN_OFS + w8) begin
                n_sig_off = r_sig_off | sh_d;
            end else if (rel && d8 >= pedsel_pkg::CERT_LEN_OFS + w8
                         && d8 < pedsel_pkg::CERT_END + w8) begin
                n_sig_len = r_sig_len | sh_d;
                if (d8 == pedsel_pkg::CERT_END - 8'd1 + w8) begin
                    if (r_sig_off != 32'd0 && sig_sum != size33) begin
                        n_err = pedsel_pkg::ST_SIG_NOT_END;
                    end else if ({1'b0, kept} <= r_lim) begin
                        n_err = pedsel_pkg::ST_OVERLAP;
                    end
                end
            end
        end
    end

    always_comb begin
        priority if (n_err != pedsel_pkg::ST_OK) begin
            digest = 1'b0;
        end else if (n_sig_off != 32'd0 && r_pos >= n_sig_off) begin
            digest = 1'b0;
        end else if (!past_dos) begin
            digest = 1'b1;
        end else if (at_or_past && d[31:8] == 24'd0
                     && ((d8 >= pedsel_pkg::CHECKSUM_OFS && d8 < pedsel_pkg::CHECKSUM_END)
                         || (d8 >= pedsel_pkg::CERT_OFS + nw8
                             && d8 < pedsel_pkg::CERT_END + nw8))) begin
            digest = 1'b0;
        end else begin
            digest = 1'b1;
        end
    end

    assign kept_lo = (n_sig_off != 32'd0) ? n_sig_off[2:0] : i_image_size[2:0];

    assign o_res.data      = i_byte;
    assign o_res.to_digest = digest;
    assign o_res.status    = n_err;
    assign o_res.is_end    = is_end;
    assign o_res.pad_cnt   = (n_err == pedsel_pkg::ST_OK) ? 3'(3'd0 - kept_lo) : 3'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 32'd0;
            r_hdr      <= 32'd0;
            r_wide     <= 1'b0;
            r_magic_lo <= 8'd0;
            r_dir      <= 32'd0;
            r_sig_off  <= 32'd0;
            r_sig_len  <= 32'd0;
            r_lim      <= 33'd0;
            r_err      <= pedsel_pkg::ST_OK;
        end else if (i_advance) begin
            if (is_end) begin
                r_pos      <= 32'd0;
                r_hdr      <= 32'd0;
                r_wide     <= 1'b0;
                r_magic_lo <= 8'd0;
                r_dir      <= 32'd0;
                r_sig_off  <= 32'd0;
                r_sig_len  <= 32'd0;
                r_lim      <= 33'd0;
                r_err      <= pedsel_pkg::ST_OK;
            end else begin
                r_pos      <= pos_inc[31:0];
                r_hdr      <= n_hdr;
                r_wide     <= n_wide;
                r_magic_lo <= n_magic_lo;
                r_dir      <= n_dir;
                r_sig_off  <= n_sig_off;
                r_sig_len  <= n_sig_len;
                r_lim      <= n_lim;
                r_err      <= n_err;
            end
        end
    end

`ifndef SYNTH
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_err != pedsel_pkg::ST_OK && !is_end) |=> (r_err == $past(r_err)))
        else $error("error code changed within an image");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && is_end) |=> (r_pos == 32'd0 && r_err == pedsel_pkg::ST_OK))
        else $error("image state not cleared after the final word");
    a_wide_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wide |-> (r_hdr >= pedsel_pkg::DOS_LEN))
        else $error("wide format set without a valid header offset");
`endif

endmodule

FILE: hw/rtl/pedsel_out.sv
// Result register with the zero padding sequencer that follows the final word.
module pedsel_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  pedsel_pkg::t_result  i_res,
    input  logic                 i_ready,
    output logic                 o_can_load,
    output logic                 o_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_to_digest,
    output logic [3:0]           o_status,
    output logic                 o_last
);

    logic                 r_valid;
    logic [2:0]           r_pad_cnt;
    logic [7:0]           r_data;
    logic                 r_to_digest;
    pedsel_pkg::t_status  r_status;
    logic                 r_last;

    assign o_can_load  = (r_pad_cnt == 3'd0) && (!r_valid || i_ready);
    assign o_valid     = r_valid;
    assign o_out_byte  = r_data;
    assign o_to_digest = r_to_digest;
    assign o_status    = r_status;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pad_cnt <= 3'd0;
        end else if (i_load) begin
            r_valid   <= 1'b1;
            r_pad_cnt <= i_res.is_end ? i_res.pad_cnt : 3'd0;
        end else if (r_valid && i_ready) begin
            if (r_pad_cnt != 3'd0) begin
                r_pad_cnt <= r_pad_cnt - 3'd1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data      <= i_res.data;
            r_to_digest <= i_res.to_digest;
            r_status    <= i_res.status;
            r_last      <= i_res.is_end && (i_res.pad_cnt == 3'd0);
        end else if (r_valid && i_ready && r_pad_cnt != 3'd0) begin
            r_data      <= 8'd0;
            r_to_digest <= 1'b1;
            r_status    <= pedsel_pkg::ST_OK;
            r_last      <= (r_pad_cnt == 3'd1);
        end
    end

`ifndef SYNTH
    a_no_load_in_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_pad_cnt == 3'd0))
        else $error("new word loaded while padding is pending");
    a_pad_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad_cnt != 3'd0) |-> (r_valid && !r_last))
        else $error("last flagged before padding completed");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && r_last && !i_load) |=> !r_valid)
        else $error("result register still full after the last word");
`endif

endmodule

FILE: hw/rtl/pe_image_digest_byte_selector.sv
// Top level of the PE image digest byte selector.
// Usage: write the image length through i_cfg_wr_en and i_cfg_wr_data while no word
// is in flight, then stream the image one byte per word on i_valid, o_ready and
// i_image_byte. Each byte comes back on o_valid, i_ready with o_out_byte, a flag
// o_to_digest that marks bytes feeding the hash, a status o_status and o_last.
// After the final byte of an image without error, up to seven zero padding words
// follow, so that the signature offset (else the image length) plus the padding is
// a multiple of eight; o_last marks the final word of the image. A nonzero status
// means the whole image is rejected. Each byte passes the input register, then the
// result register. One byte is taken each cycle while the receiver keeps up and no
// padding is issued; the two registers are separate stages, so a new byte is taken
// while a result waits. While padding is issued, no byte moves on to the result
// register. A stalled receiver holds the result register, then the input register.
// Synchronous reset clears the image length, the image state and both stages.
module pe_image_digest_byte_selector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_image_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_to_digest,
    output logic [3:0]  o_status,
    output logic        o_last
);

    logic [31:0]         r_image_size;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                can_load;
    logic                advance;
    pedsel_pkg::t_result res;

    assign advance = r_in_valid && can_load;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 32'd0;
            r_in_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_image_size <= i_cfg_wr_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_image_byte;
        end
    end

    pedsel_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_byte       (r_in_byte),
        .i_image_size (r_image_size),
        .o_res        (res)
    );

    pedsel_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res       (res),
        .i_ready     (i_ready),
        .o_can_load  (can_load),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_to_digest (o_to_digest),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench that streams PE images through the byte selector and checks each word.
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 40000;
    localparam int          HOLD_LEN    = 40;

    typedef struct {
        logic [7:0]          data;
        logic                digest;
        pedsel_pkg::t_status status;
        logic                last;
    } t_word;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_image_byte  = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_to_digest;
    logic [3:0]  o_status;
    logic        o_last;

    // Predicted state of the selector.
    logic [31:0]         sel_len     = '0;
    logic [31:0]         sel_pos     = '0;
    logic [31:0]         sel_hdr     = '0;
    logic                sel_wide    = 1'b0;
    logic [15:0]         sel_magic   = '0;
    logic [31:0]         sel_dirs    = '0;
    logic [31:0]         sel_sig_ofs = '0;
    logic [31:0]         sel_sig_len = '0;
    pedsel_pkg::t_status sel_err     = pedsel_pkg::ST_OK;

    t_word       pending_words[$];
    t_word       head_word;
    logic [7:0]  image_buf[$];
    logic [31:0] image_len;
    int          n_fail      = 0;
    int          hold_cycles = 0;
    bit          no_idle     = 1'b0;
    int unsigned cycle_cnt   = 0;

    pe_image_digest_byte_selector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_image_byte  (i_image_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_to_digest   (o_to_digest),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void clear_image();
        sel_pos     = '0;
        sel_hdr     = '0;
        sel_wide    = 1'b0;
        sel_magic   = '0;
        sel_dirs    = '0;
        sel_sig_ofs = '0;
        sel_sig_len = '0;
        sel_err     = pedsel_pkg::ST_OK;
    endfunction

    function automatic void inspect_byte(input logic [31:0] q, input logic [7:0] b);
        logic [63:0] h;
        logic [63:0] len;
        logic [63:0] w;
        logic [63:0] d;
        logic [63:0] kept;
        logic [7:0]  want;
        h   = sel_hdr;
        len = sel_len;
        if (q == 0) begin
            if (len <= 2 || b != pedsel_pkg::CHAR_M) sel_err = pedsel_pkg::ST_NOT_PE;
            return;
        end
        if (q == 1) begin
            if (b != pedsel_pkg::CHAR_Z) sel_err = pedsel_pkg::ST_NOT_PE;
            else if (len < 64) sel_err = pedsel_pkg::ST_DOS_SHORT;
            return;
        end
        if (q >= 60 && q <= 63) begin
            sel_hdr = sel_hdr | (32'(b) << (8 * (q - 60)));
            if (q == 63) begin
                h = sel_hdr;
                if (h + 160 > len) sel_err = pedsel_pkg::ST_OFFSET_HIGH;
                else if (h < 64) sel_err = pedsel_pkg::ST_OVERLAP;
            end
            return;
        end
        if (q < 64 || 64'(q) < h) return;
        d = 64'(q) - h;
        w = sel_wide ? 64'd16 : 64'd0;
        if (d < 4) begin
            want = (d == 0) ? pedsel_pkg::CHAR_P : (d == 1) ? pedsel_pkg::CHAR_E : 8'h00;
            if (b != want) sel_err = pedsel_pkg::ST_NO_MARKER;
        end else if (d == 24) begin
            sel_magic = {8'h00, b};
        end else if (d == 25) begin
            sel_magic = sel_magic | {b, 8'h00};
            if (sel_magic == pedsel_pkg::MAGIC_WIDE) sel_wide = 1'b1;
            else if (sel_magic == pedsel_pkg::MAGIC_NARROW) sel_wide = 1'b0;
            else sel_err = pedsel_pkg::ST_BAD_MAGIC;
        end else if (d >= 116 + w && d < 120 + w) begin
            sel_dirs = sel_dirs | (32'(b) << (8 * (d - 116 - w)));
            if (d == 119 + w) begin
                if (sel_dirs < 5) sel_err = pedsel_pkg::ST_FEW_DIRS;
                else if (len < h + 160 + w) sel_err = pedsel_pkg::ST_HDR_SHORT;
            end
        end else if (d >= 152 + w && d < 156 + w) begin
            sel_sig_ofs = sel_sig_ofs | (32'(b) << (8 * (d - 152 - w)));
        end else if (d >= 156 + w && d < 160 + w) begin
            sel_sig_len = sel_sig_len | (32'(b) << (8 * (d - 156 - w)));
            if (d == 159 + w) begin
                kept = (sel_sig_ofs != 0) ? 64'(sel_sig_ofs) : len;
                if (sel_sig_ofs != 0 && 64'(sel_sig_ofs) + 64'(sel_sig_len) != len)
                    sel_err = pedsel_pkg::ST_SIG_NOT_END;
                else if (kept <= h + 160 + w)
                    sel_err = pedsel_pkg::ST_OVERLAP;
            end
        end
    endfunction

    function automatic logic feeds_digest(input logic [31:0] q);
        logic [63:0] h;
        logic [63:0] w;
        logic [63:0] p;
        h = sel_hdr;
        w = sel_wide ? 64'd16 : 64'd0;
        p = q;
        if (sel_err != pedsel_pkg::ST_OK) return 1'b0;
        if (sel_sig_ofs != 0 && q >= sel_sig_ofs) return 1'b0;
        if (q < 64) return 1'b1;
        if (p >= h + 88 && p < h + 92) return 1'b0;
        if (p >= h + 152 + w && p < h + 160 + w) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_selection(input logic [7:0] b);
        logic [31:0] q;
        logic [31:0] kept;
        logic        fin;
        int          pad;
        q   = sel_pos;
        fin = (64'(q) + 1 >= 64'(sel_len));
        pad = 0;
        if (sel_err == pedsel_pkg::ST_OK) inspect_byte(q, b);
        if (fin && sel_err == pedsel_pkg::ST_OK) begin
            kept = (sel_sig_ofs != 0) ? sel_sig_ofs : sel_len;
            pad  = (8 - int'(kept[2:0])) % 8;
        end
        pending_words.push_back('{data: b, digest: feeds_digest(q), status: sel_err,
                                  last: fin && pad == 0});
        for (int i = 1; i <= pad; i++)
            pending_words.push_back('{data: 8'h00, digest: 1'b1,
                                      status: pedsel_pkg::ST_OK, last: i == pad});
        if (fin) clear_image();
        else sel_pos = q + 1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: out_byte %h status %0d", o_out_byte, o_status);
                n_fail++;
            end else begin
                head_word = pending_words.pop_front();
                if (o_out_byte !== head_word.data) begin
                    $error("out_byte: expected %h, got %h", head_word.data, o_out_byte);
                    n_fail++;
                end
                if (o_to_digest !== head_word.digest) begin
                    $error("to_digest: expected %b, got %b", head_word.digest, o_to_digest);
                    n_fail++;
                end
                if (o_status !== head_word.status) begin
                    $error("status: expected %0d, got %0d", head_word.status, o_status);
                    n_fail++;
                end
                if (o_last !== head_word.last) begin
                    $error("last: expected %b, got %b", head_word.last, o_last);
                    n_fail++;
                end
            end
        end
    end

    // The receiver stalls now and then, and for a long stretch when asked to.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99, 0) >= 7);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("pe_image_digest_byte_selector test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(99, 0) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_image_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_selection(b);
    endtask

    task automatic set_image_len(input logic [31:0] len);
        while (pending_words.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sel_len = len;
    endtask

    task automatic send_image();
        set_image_len(image_len);
        for (int unsigned i = 0; i < image_len; i++) send_byte(image_buf[i]);
        i_valid <= 1'b0;
    endtask

    function automatic void put_word32(input logic [31:0] ofs, input logic [31:0] v);
        for (int i = 0; i < 4; i++) image_buf[ofs + i] = v[8 * i +: 8];
    endfunction

    task automatic build_pe(input bit with_sig);
        logic [31:0] h;
        logic [31:0] w;
        logic [31:0] slen;
        logic [31:0] dirs;
        h    = $urandom_range(68, 64);
        w    = $urandom_range(1, 0) ? 32'd16 : 32'd0;
        slen = with_sig ? $urandom_range(8, 1) : $urandom;
        image_len = h + 160 + w + $urandom_range(8, 1) + (with_sig ? slen : 0);
        dirs = $urandom_range(1, 0) ? $urandom : $urandom_range(16, 5);
        if (dirs < 5) dirs = dirs + 5;
        image_buf.delete();
        for (int unsigned i = 0; i < image_len; i++) image_buf.push_back($urandom_range(255, 0));
        image_buf[0]      = pedsel_pkg::CHAR_M;
        image_buf[1]      = pedsel_pkg::CHAR_Z;
        put_word32(60, h);
        put_word32(h, {8'h00, 8'h00, pedsel_pkg::CHAR_E, pedsel_pkg::CHAR_P});
        image_buf[h + 24] = w != 0 ? pedsel_pkg::MAGIC_WIDE[7:0]
                                   : pedsel_pkg::MAGIC_NARROW[7:0];
        image_buf[h + 25] = w != 0 ? pedsel_pkg::MAGIC_WIDE[15:8]
                                   : pedsel_pkg::MAGIC_NARROW[15:8];
        put_word32(h + 116 + w, dirs);
        put_word32(h + 152 + w, with_sig ? image_len - slen : 32'd0);
        put_word32(h + 156 + w, slen);
    endtask

    task automatic build_noise();
        image_len = $urandom_range(40, 8);
        image_buf.delete();
        for (int unsigned i = 0; i < image_len; i++) image_buf.push_back($urandom_range(255, 0));
        if ($urandom_range(1, 0)) begin
            image_buf[0] = pedsel_pkg::CHAR_M;
            image_buf[1] = pedsel_pkg::CHAR_Z;
        end
    endtask

    task automatic test_short_images();
        set_image_len(32'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        i_valid <= 1'b0;
        set_image_len(32'd1);
        send_byte(pedsel_pkg::CHAR_M);
        i_valid <= 1'b0;
        set_image_len(32'd2);
        send_byte(pedsel_pkg::CHAR_M);
        send_byte(pedsel_pkg::CHAR_Z);
        i_valid <= 1'b0;
        set_image_len(32'd3);
        send_byte(pedsel_pkg::CHAR_M);
        send_byte(pedsel_pkg::CHAR_Z);
        send_byte(8'h00);
        i_valid <= 1'b0;
        set_image_len(32'd4);
        send_byte(8'hA5);
        send_byte(pedsel_pkg::CHAR_Z);
        send_byte(8'hFF);
        send_byte(8'h00);
        i_valid <= 1'b0;
    endtask

    task automatic test_length_extremes();
        set_image_len(32'hFFFF_FFFF);
        send_byte(pedsel_pkg::CHAR_M);
        send_byte(pedsel_pkg::CHAR_Z);
        send_byte(8'hAA);
        i_valid <= 1'b0;
        // A zero length written part way through makes the next byte the final one.
        set_image_len(32'd0);
        send_byte(8'h55);
        i_valid <= 1'b0;
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        build_pe(1'b1);
        send_image();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        build_noise();
        hold_cycles = HOLD_LEN;
        send_image();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_images();
        test_length_extremes();
        test_back_to_back();
        test_backpressure();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("pe_image_digest_byte_selector test passed");
        end else begin
            $display("pe_image_digest_byte_selector test failed");
        end
        $finish;
    end
endmodule
